>>> rtl/msbr_pkg.sv
// msbr_pkg: shared constants, codes and types of the msb-first bit reader
// used by msbr_extract, the top level, the checker and the testbench; depends on nothing

package msbr_pkg;

    localparam int RING_BYTES = 1024;
    localparam int RING_AW    = $clog2(RING_BYTES);
    localparam int MAX_BITS   = 32;

    localparam int IDX_W  = 29;
    localparam int POS_W  = 32;
    localparam int CNT_IW = 6;
    localparam int VAL_W  = 32;

    // a window of MAX_BITS bits at any bit offset spans this many bytes
    localparam int MAX_BYTES = (MAX_BITS + 6) / 8 + 1;
    localparam int ACC_W     = MAX_BYTES * 8;
    localparam int NB_W      = $clog2(MAX_BYTES + 1);

    localparam logic [2:0] REQ_PUSH  = 3'd0;
    localparam logic [2:0] REQ_PEEK  = 3'd1;
    localparam logic [2:0] REQ_POP   = 3'd2;
    localparam logic [2:0] REQ_ALIGN = 3'd3;
    localparam logic [2:0] REQ_GET   = 3'd4;
    localparam logic [2:0] REQ_SET   = 3'd5;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_DATA = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // control from the sequencer to the extract unit
    typedef struct packed {
        logic              capture;
        logic [2:0]        rsh;
        logic [CNT_IW-1:0] nbits;
    } t_ext_ctl;

endpackage

>>> rtl/msbr_ram.sv
// msbr_ram: generic single write port, single read port ram with registered read
// no dependencies

module msbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/msbr_extract.sv
// msbr_extract: byte accumulator and bit window select of the bit reader
// depends on msbr_pkg

module msbr_extract (
    input  logic                      i_clk,
    input  msbr_pkg::t_ext_ctl        i_ctl,
    input  logic [7:0]                i_rd_byte,
    output logic [msbr_pkg::VAL_W-1:0] o_value
);

    logic [msbr_pkg::ACC_W-1:0] r_acc;
    logic [msbr_pkg::ACC_W-1:0] shifted;
    logic [msbr_pkg::VAL_W-1:0] mask;

    // bytes enter at the bottom, first byte ends up highest
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_acc <= {r_acc[msbr_pkg::ACC_W-9:0], i_rd_byte};
        end
    end

    always_comb begin
        shifted = r_acc >> i_ctl.rsh;
        mask    = ~({msbr_pkg::VAL_W{1'b1}} << i_ctl.nbits);
        o_value = shifted[msbr_pkg::VAL_W-1:0] & mask;
    end

endmodule

>>> rtl/msb_first_bit_reader.sv
// msb_first_bit_reader: top level, request sequencer and reader state
// depends on msbr_pkg, msbr_ram and msbr_extract

// MSB-first bitstream reader over a byte ring.
// Input channel (i_valid/o_ready) carries one request per transfer: push a
// stream byte, peek or pop 0 to MAX_BITS bits, align to the next byte, get the
// bit position, or set a new bit position. The output channel (o_valid/i_ready)
// returns exactly one result per request: extracted bits, the bit position
// after the request, and a status (ok, not enough data, buffer full).
// Push, align, get, set, zero-bit and short-data reads and unknown codes are
// decided in the transfer cycle; the result is registered in the sequencer and
// moves to the output register once that register is free.
// A peek or pop of n bits at offset k reads ceil((k+n)/8) bytes, one per cycle
// through the single read port of the ring ram; each byte passes the registered
// ram read into the accumulator, the finish state selects the window and the
// done state hands the result to the output register.
// One request is in flight at a time and o_ready is high only in idle. The next
// request is taken while a finished result still waits in the output register;
// if the receiver stalls, the following result waits in the sequencer until the
// output register frees up, and no input is taken then.
// Synchronous active-low reset clears position and fill count and empties the output
// register; ring contents stay undefined until pushed. A set position flushes
// the ring: refill starts at the byte index rounded down to the ring size.

module msb_first_bit_reader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic [5:0]  i_bit_count,
    input  logic [31:0] i_new_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_bits_value,
    output logic [31:0] o_bit_position,
    output logic [1:0]  o_status
);

    localparam int IDX_W  = msbr_pkg::IDX_W;
    localparam int POS_W  = msbr_pkg::POS_W;
    localparam int AW     = msbr_pkg::RING_AW;
    localparam int NB_W   = msbr_pkg::NB_W;
    localparam int CNT_IW = msbr_pkg::CNT_IW;
    localparam int VAL_W  = msbr_pkg::VAL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FIN,
        S_DONE
    } t_state;

    t_state r_state;

    // reader state
    logic [IDX_W-1:0] r_rbi;   // read byte index
    logic [2:0]       r_off;   // bit offset in byte, 0 is the msb
    logic [IDX_W-1:0] r_fill;  // absolute index of next byte to push

    // read sequencing
    logic [AW-1:0]     r_raddr;
    logic [NB_W-1:0]   r_iss;
    logic [NB_W-1:0]   r_cap;
    logic              r_pend;
    logic              r_pop;
    logic [POS_W-1:0]  r_end;
    logic [2:0]        r_rsh;
    logic [CNT_IW-1:0] r_nbits;

    // result waiting for the output register
    logic [VAL_W-1:0]  r_res_value;
    logic [POS_W-1:0]  r_res_pos;
    msbr_pkg::t_status r_res_status;

    // output register
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_value;
    logic [POS_W-1:0]  r_out_pos;
    msbr_pkg::t_status r_out_status;

    logic              in_xfer;
    logic              out_free;
    logic [CNT_IW-1:0] nbits;
    logic [POS_W-1:0]  cur_pos;
    logic [POS_W:0]    end_pos;
    logic [POS_W:0]    last_bit;
    logic              missing;
    logic [IDX_W-1:0]  fill_gap;
    logic              full;
    logic [6:0]        win_last;
    logic [NB_W-1:0]   nbytes;
    logic [IDX_W-1:0]  set_rbi;
    logic              rd_en;
    logic [7:0]        rd_byte;
    logic [VAL_W-1:0]  ext_value;
    msbr_pkg::t_ext_ctl ext_ctl;
    msbr_pkg::t_status req_status;
    logic [POS_W-1:0]  req_pos;
    logic              req_read;

    assign o_ready  = (r_state == S_IDLE);
    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        nbits    = (i_bit_count > CNT_IW'(msbr_pkg::MAX_BITS)) ?
                   CNT_IW'(msbr_pkg::MAX_BITS) : i_bit_count;
        cur_pos  = {r_rbi, r_off};
        end_pos  = {1'b0, cur_pos} + (POS_W+1)'(nbits);
        last_bit = end_pos - (POS_W+1)'(1);
        // last byte touched must already be buffered
        missing  = last_bit[POS_W:3] >= (POS_W-2)'(r_fill);
        fill_gap = r_fill - r_rbi;
        full     = ((r_fill >= r_rbi) && (fill_gap >= IDX_W'(msbr_pkg::RING_BYTES))) ||
                   (r_fill == {IDX_W{1'b1}});
        // bit index of the window end counted from the first byte's msb
        win_last = 7'(r_off) + 7'(nbits) - 7'd1;
        nbytes   = NB_W'(win_last[6:3]) + NB_W'(1);
        set_rbi  = i_new_position[POS_W-1:3];
    end

    // outcome of a request decided in its transfer cycle
    always_comb begin
        req_status = msbr_pkg::ST_OK;
        req_pos    = cur_pos;
        req_read   = 1'b0;
        unique case (i_req_type)
            msbr_pkg::REQ_PUSH: begin
                if (full) begin
                    req_status = msbr_pkg::ST_FULL;
                end
            end
            msbr_pkg::REQ_PEEK, msbr_pkg::REQ_POP: begin
                if (nbits != '0) begin
                    if (missing) begin
                        req_status = msbr_pkg::ST_NO_DATA;
                    end else begin
                        req_read = 1'b1;
                    end
                end
            end
            msbr_pkg::REQ_ALIGN: begin
                if (r_off != 3'd0) begin
                    req_pos = {r_rbi + IDX_W'(1), 3'd0};
                end
            end
            msbr_pkg::REQ_SET: begin
                req_pos = i_new_position;
            end
            default: begin
                // get position and unknown codes change nothing
            end
        endcase
    end

    assign rd_en = (r_state == S_READ) && (r_iss != '0);

    msbr_ram #(
        .WIDTH (8),
        .DEPTH (msbr_pkg::RING_BYTES)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && (i_req_type == msbr_pkg::REQ_PUSH) && !full),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_data_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_raddr),
        .o_rd_data (rd_byte)
    );

    always_comb begin
        ext_ctl.capture = r_pend;
        ext_ctl.rsh     = r_rsh;
        ext_ctl.nbits   = r_nbits;
    end

    msbr_extract u_ext (
        .i_clk     (i_clk),
        .i_ctl     (ext_ctl),
        .i_rd_byte (rd_byte),
        .o_value   (ext_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rbi       <= '0;
            r_off       <= '0;
            r_fill      <= '0;
            r_iss       <= '0;
            r_cap       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: loaded from the sequencer, emptied by the receiver
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_pend <= rd_en;

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_res_value  <= '0;
                        r_res_status <= req_status;
                        r_res_pos    <= req_pos;
                        r_state      <= req_read ? S_READ : S_DONE;
                        unique case (i_req_type)
                            msbr_pkg::REQ_PUSH: begin
                                if (!full) begin
                                    r_fill <= r_fill + IDX_W'(1);
                                end
                            end
                            msbr_pkg::REQ_PEEK, msbr_pkg::REQ_POP: begin
                                if (req_read) begin
                                    r_raddr <= r_rbi[AW-1:0];
                                    r_iss   <= nbytes;
                                    r_cap   <= nbytes;
                                    r_pop   <= (i_req_type == msbr_pkg::REQ_POP);
                                    r_end   <= end_pos[POS_W-1:0];
                                    r_rsh   <= 3'd7 - win_last[2:0];
                                    r_nbits <= nbits;
                                end
                            end
                            msbr_pkg::REQ_ALIGN: begin
                                if (r_off != 3'd0) begin
                                    r_rbi <= r_rbi + IDX_W'(1);
                                    r_off <= 3'd0;
                                end
                            end
                            msbr_pkg::REQ_SET: begin
                                r_rbi  <= set_rbi;
                                r_off  <= i_new_position[2:0];
                                // flush: refill from the ring-aligned byte base
                                r_fill <= set_rbi & ~IDX_W'(msbr_pkg::RING_BYTES - 1);
                            end
                            default: begin
                                // get position and unknown codes change nothing
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (rd_en) begin
                        r_raddr <= r_raddr + AW'(1);
                        r_iss   <= r_iss - NB_W'(1);
                    end
                    if (r_pend) begin
                        r_cap <= r_cap - NB_W'(1);
                        if (r_cap == NB_W'(1)) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_res_value  <= ext_value;
                    r_res_status <= msbr_pkg::ST_OK;
                    if (r_pop) begin
                        r_rbi     <= r_end[POS_W-1:3];
                        r_off     <= r_end[2:0];
                        r_res_pos <= r_end;
                    end else begin
                        r_res_pos <= cur_pos;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_value  <= r_res_value;
                        r_out_pos    <= r_res_pos;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_bits_value   = r_out_value;
    assign o_bit_position = r_out_pos;
    assign o_status       = r_out_status;

endmodule

>>> rtl/msbr_checker.sv
// msbr_checker: port-level assertions for msb_first_bit_reader, with its bind
// depends on msbr_pkg and the top level's port list

module msbr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_bits_value,
    input logic [1:0]  o_status
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_bits_value) && $stable(o_status)))
        else $error("result dropped or changed while stalled");

    // only one request in flight: ready drops after each transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while another is in flight");

    // a failed request returns no bits
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != msbr_pkg::ST_OK)) |-> (o_bits_value == 32'd0))
        else $error("bits returned with an error status");

    // status code stays in range
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == msbr_pkg::ST_OK) || (o_status == msbr_pkg::ST_NO_DATA) ||
                     (o_status == msbr_pkg::ST_FULL)))
        else $error("undefined status code");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered after reset");

endmodule

bind msb_first_bit_reader msbr_checker u_msbr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_bits_value (o_bits_value),
    .o_status     (o_status)
);

>>> test/tb_msb_first_bit_reader.sv
// tb_msb_first_bit_reader: self-checking testbench of the msb-first bit reader
// depends on msbr_pkg and the rtl top msb_first_bit_reader

module tb_msb_first_bit_reader;

    localparam int RING_BYTES = msbr_pkg::RING_BYTES;
    localparam int RING_AW    = msbr_pkg::RING_AW;
    localparam int IDX_W      = msbr_pkg::IDX_W;
    localparam int MAX_BITS   = msbr_pkg::MAX_BITS;

    // generous bound on the whole run, far above the slowest correct run
    localparam int CYCLE_LIMIT = 500000;
    // cycles to keep watching after the last result, longer than the slowest read
    localparam int TAIL_CYCLES = 20;

    // one result transfer as the reader should present it
    typedef struct {
        logic [31:0]       bits_value;
        logic [31:0]       bit_position;
        msbr_pkg::t_status status;
    } t_reader_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [2:0]  i_req_type     = msbr_pkg::REQ_GET;
    logic [7:0]  i_data_byte    = '0;
    logic [5:0]  i_bit_count    = '0;
    logic [31:0] i_new_position = '0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [31:0] o_bits_value;
    logic [31:0] o_bit_position;
    logic [1:0]  o_status;

    // predictor state: ring image, read point and fill count
    logic [7:0]       ring_image [RING_BYTES];
    logic [IDX_W-1:0] read_byte;
    logic [2:0]       read_offset;   // bits already consumed in the read byte
    logic [IDX_W-1:0] fill_count;

    t_reader_result pending_results[$];
    t_reader_result head_result;

    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    msb_first_bit_reader DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_data_byte    (i_data_byte),
        .i_bit_count    (i_bit_count),
        .i_new_position (i_new_position),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bits_value   (o_bits_value),
        .o_bit_position (o_bit_position),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // advance the predictor by one request and return the result it implies
    function automatic t_reader_result predict_reader_result(
        input logic [2:0]  req,
        input logic [7:0]  data,
        input logic [5:0]  cnt,
        input logic [31:0] npos
    );
        t_reader_result r;
        logic [33:0]    start_bit;
        logic [33:0]    last_byte;
        logic [33:0]    cur_bit;
        logic [33:0]    stop_bit;
        logic [7:0]     cur_byte;
        int             nbits;
        int             k;
        r.bits_value = '0;
        r.status     = msbr_pkg::ST_OK;
        case (req)
            msbr_pkg::REQ_PUSH: begin
                // refused when a whole ring is unread, or at the top of the count
                if ((fill_count >= read_byte && fill_count - read_byte >= RING_BYTES)
                        || (&fill_count)) begin
                    r.status = msbr_pkg::ST_FULL;
                end else begin
                    ring_image[fill_count[RING_AW-1:0]] = data;
                    fill_count = fill_count + 1'b1;
                end
            end
            msbr_pkg::REQ_PEEK, msbr_pkg::REQ_POP: begin
                // counts above the window width are clamped
                nbits = (cnt > MAX_BITS) ? MAX_BITS : int'(cnt);
                if (nbits > 0) begin
                    start_bit = {2'b00, read_byte, read_offset};
                    last_byte = (start_bit + nbits - 1) >> 3;
                    if (last_byte >= fill_count) begin
                        r.status = msbr_pkg::ST_NO_DATA;
                    end else begin
                        for (k = 0; k < nbits; k++) begin
                            cur_bit  = start_bit + k;
                            cur_byte = ring_image[cur_bit[RING_AW+2:3]];
                            r.bits_value = {r.bits_value[30:0], cur_byte[7 - cur_bit[2:0]]};
                        end
                        if (req == msbr_pkg::REQ_POP) begin
                            stop_bit    = start_bit + nbits;
                            read_byte   = stop_bit[31:3];
                            read_offset = stop_bit[2:0];
                        end
                    end
                end
            end
            msbr_pkg::REQ_ALIGN: begin
                if (read_offset != 3'd0) begin
                    read_byte   = read_byte + 1'b1;
                    read_offset = 3'd0;
                end
            end
            msbr_pkg::REQ_SET: begin
                // flush: refill restarts at the ring-aligned byte base
                read_byte   = npos[31:3];
                read_offset = npos[2:0];
                fill_count  = IDX_W'((read_byte / RING_BYTES) * RING_BYTES);
            end
            default: begin
            end
        endcase
        r.bit_position = {read_byte, read_offset};
        return r;
    endfunction

    // one request transfer, with random idle cycles before it
    task automatic send_request(
        input logic [2:0]  req,
        input logic [7:0]  data,
        input logic [5:0]  cnt,
        input logic [31:0] npos
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_data_byte    <= data;
        i_bit_count    <= cnt;
        i_new_position <= npos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(predict_reader_result(req, data, cnt, npos));
    endtask

    // hold off the sender until every outstanding result has been returned
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic push_random_bytes(input int n);
        repeat (n) send_request(msbr_pkg::REQ_PUSH, 8'($urandom), 6'($urandom), $urandom);
    endtask

    // byte pattern, extreme counts, clamping, short data, align, unknown codes
    task automatic test_directed_reads();
        send_request(msbr_pkg::REQ_GET, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
        send_request(msbr_pkg::REQ_PEEK, 8'h00, 6'd8, 32'h0);   // empty ring, short data
        send_request(msbr_pkg::REQ_PEEK, 8'h00, 6'd0, 32'h0);   // zero bits on empty ring
        send_request(msbr_pkg::REQ_PUSH, 8'hFF, 6'd0, 32'h0);
        send_request(msbr_pkg::REQ_PUSH, 8'h00, 6'd0, 32'h0);
        send_request(msbr_pkg::REQ_PUSH, 8'hA5, 6'd0, 32'h0);
        send_request(msbr_pkg::REQ_PUSH, 8'h5A, 6'd0, 32'h0);
        send_request(msbr_pkg::REQ_PUSH, 8'h80, 6'd0, 32'h0);
        send_request(msbr_pkg::REQ_PUSH, 8'h01, 6'd0, 32'h0);
        send_request(msbr_pkg::REQ_PEEK, 8'h00, 6'd32, 32'h0);  // full window, aligned
        send_request(msbr_pkg::REQ_POP, 8'h00, 6'd1, 32'h0);
        send_request(msbr_pkg::REQ_POP, 8'h00, 6'd33, 32'h0);   // clamped, five bytes
        send_request(msbr_pkg::REQ_POP, 8'h00, 6'd63, 32'h0);   // clamped, beyond the data
        send_request(msbr_pkg::REQ_PEEK, 8'h00, 6'd7, 32'h0);
        send_request(msbr_pkg::REQ_ALIGN, 8'h00, 6'd0, 32'h0);
        send_request(msbr_pkg::REQ_ALIGN, 8'h00, 6'd0, 32'h0);  // already aligned
        send_request(msbr_pkg::REQ_POP, 8'h00, 6'd8, 32'h0);
        send_request(msbr_pkg::REQ_PEEK, 8'h00, 6'd1, 32'h0);   // ring drained
        send_request(msbr_pkg::REQ_POP, 8'h00, 6'd0, 32'h0);
        send_request(3'd6, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
        send_request(3'd7, 8'h55, 6'h2A, 32'hAAAA_AAAA);
        send_request(msbr_pkg::REQ_GET, 8'h00, 6'd0, 32'h0);
        wait_results_drained();
    endtask

    // set position to the very top, align wraps; refill behind the read point
    task automatic test_position_moves();
        send_request(msbr_pkg::REQ_SET, 8'h00, 6'd0, 32'hFFFF_FFFF);
        send_request(msbr_pkg::REQ_ALIGN, 8'h00, 6'd0, 32'h0);
        send_request(msbr_pkg::REQ_PUSH, 8'h3C, 6'd0, 32'h0);   // fill far above read point
        send_request(msbr_pkg::REQ_SET, 8'h00, 6'd0, 32'h0000_2345);
        push_random_bytes(5);
        send_request(msbr_pkg::REQ_PEEK, 8'h00, 6'd1, 32'h0);
        send_request(msbr_pkg::REQ_SET, 8'h00, 6'd0, 32'h0000_0013);
        push_random_bytes(4);
        send_request(msbr_pkg::REQ_PEEK, 8'h00, 6'd16, 32'h0);
        send_request(msbr_pkg::REQ_POP, 8'h00, 6'd3, 32'h0);
        send_request(msbr_pkg::REQ_PEEK, 8'h00, 6'd32, 32'h0);
        send_request(msbr_pkg::REQ_POP, 8'h00, 6'd10, 32'h0);
        wait_results_drained();
    endtask

    // read point wraps below a fill base far ahead: the ring counts as full
    task automatic test_ring_full();
        send_request(msbr_pkg::REQ_SET, 8'h00, 6'd0, 32'hFFFF_FFFC);
        send_request(msbr_pkg::REQ_ALIGN, 8'h00, 6'd0, 32'h0);
        push_random_bytes(3);
        send_request(msbr_pkg::REQ_GET, 8'h00, 6'd0, 32'h0);
        send_request(msbr_pkg::REQ_SET, 8'h00, 6'd0, 32'h0000_0000);
        push_random_bytes(2);
        send_request(msbr_pkg::REQ_POP, 8'h00, 6'd16, 32'h0);
        send_request(msbr_pkg::REQ_PEEK, 8'h00, 6'd1, 32'h0);
        wait_results_drained();
    endtask

    // positions near the top of the range; pushes land behind the read point
    task automatic test_counter_top();
        send_request(msbr_pkg::REQ_SET, 8'h00, 6'd0, 32'hFFFF_FF00);
        push_random_bytes(4);
        send_request(msbr_pkg::REQ_PEEK, 8'h00, 6'd8, 32'h0);   // still behind the read point
        send_request(msbr_pkg::REQ_POP, 8'h00, 6'd32, 32'h0);
        send_request(msbr_pkg::REQ_SET, 8'h00, 6'd0, 32'hFFFF_FFFD);
        send_request(msbr_pkg::REQ_GET, 8'h00, 6'd0, 32'h0);
        send_request(msbr_pkg::REQ_ALIGN, 8'h00, 6'd0, 32'h0);
        wait_results_drained();
    endtask

    // mostly pushes and reads, with occasional moves near a ring base
    task automatic test_random_stream(input int n_items);
        int          sel;
        logic [5:0]  cnt;
        logic [31:0] npos;
        repeat (n_items) begin
            sel  = $urandom_range(99);
            cnt  = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32));
            npos = $urandom;
            if (sel < 45) begin
                send_request(msbr_pkg::REQ_PUSH, 8'($urandom), 6'($urandom), $urandom);
            end else if (sel < 63) begin
                send_request(msbr_pkg::REQ_PEEK, 8'($urandom), cnt, $urandom);
            end else if (sel < 84) begin
                send_request(msbr_pkg::REQ_POP, 8'($urandom), cnt, $urandom);
            end else if (sel < 88) begin
                send_request(msbr_pkg::REQ_ALIGN, 8'($urandom), cnt, $urandom);
            end else if (sel < 92) begin
                send_request(msbr_pkg::REQ_GET, 8'($urandom), cnt, $urandom);
            end else if (sel < 97) begin
                // keep the read byte close to the refill base so reads resume soon
                if ($urandom_range(3) != 0) npos[12:3] = 10'($urandom_range(7));
                send_request(msbr_pkg::REQ_SET, 8'($urandom), cnt, npos);
            end else begin
                send_request(3'($urandom_range(7, 6)), 8'($urandom), cnt, npos);
            end
        end
        wait_results_drained();
    endtask

    // receiver stalls and result checking
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                err_cnt++;
                $display("%0t: result with none expected: bits %h position %h status %0d",
                         $time, o_bits_value, o_bit_position, o_status);
            end else begin
                head_result = pending_results.pop_front();
                if (o_bits_value !== head_result.bits_value) begin
                    err_cnt++;
                    $display("%0t: bits_value mismatch: expected %h, actual %h",
                             $time, head_result.bits_value, o_bits_value);
                end
                if (o_bit_position !== head_result.bit_position) begin
                    err_cnt++;
                    $display("%0t: bit_position mismatch: expected %h, actual %h",
                             $time, head_result.bit_position, o_bit_position);
                end
                if (o_status !== head_result.status) begin
                    err_cnt++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, head_result.status, o_status);
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        read_byte   = '0;
        read_offset = '0;
        fill_count  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // light sender gaps, heavy receiver stalls
        send_idle_pct = 26;
        recv_idle_pct = 81;
        test_directed_reads();
        test_position_moves();
        test_random_stream(110);

        // heavy sender gaps, light receiver stalls
        send_idle_pct = 81;
        recv_idle_pct = 26;
        test_ring_full();
        test_random_stream(110);

        // back to back, no stalls
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_counter_top();
        test_random_stream(110);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/msbr_pkg.sv
rtl/msbr_ram.sv
rtl/msbr_extract.sv
rtl/msb_first_bit_reader.sv
rtl/msbr_checker.sv
test/tb_msb_first_bit_reader.sv
